>>> rtl/core/assert_macros.svh
// Assertion macros shared by the transcoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/mu8_pkg.sv
// Types, constants and charset tables of the Mac Roman / UTF-8 transcoder
package mu8_pkg;

  localparam logic DIR_ROMAN_TO_UTF8 = 1'b0;
  localparam logic DIR_UTF8_TO_ROMAN = 1'b1;

  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0] UTF8_CONT     = 8'h80;

  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] last;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } res_t;

  // code points of bytes 0x80..0xFF
  localparam logic [15:0] ROMAN_HI [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  function automatic logic [15:0] roman_to_ucs(input logic [7:0] b);
    logic [15:0] cp;
    cp = b[7] ? ROMAN_HI[b[6:0]] : {8'h00, b};
    return cp;
  endfunction

  function automatic logic [7:0] ucs_to_roman(input logic [15:0] cp);
    logic [7:0] r;
    r = CHAR_QUESTION;
    if (cp <= 16'h007F) begin
      r = cp[7:0];
    end else begin
      for (int k = 0; k < 128; k++) begin
        if (ROMAN_HI[k] == cp) begin
          r = {1'b1, 7'(k)};
        end
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/macroman_utf8_transcoder_core.sv
// Mac Roman / UTF-8 byte-stream transcoder: input register, converter, result buffer
//
// Converts a byte stream between Mac Roman and UTF-8 (16-bit plane); cfg_wdata
// selects the direction (0: Mac Roman to UTF-8, 1: UTF-8 to Mac Roman), and any
// write also drops a partial UTF-8 sequence. A zero byte ends a string, gives no
// output and drops a partial sequence. Each accepted byte is held in the input
// register, converted, and its 0 to 3 output bytes loaded into a three-entry
// result buffer that drains one byte per cycle while out_tready is high; out_tlast
// marks the final byte produced by an input byte. Direction 1 and ASCII in
// direction 0 run at one byte per cycle while out_tready is high; in direction 0
// the next byte waits in the input register while the single output port of the
// result buffer drains the UTF-8 bytes of the last one. Write the direction only while idle.
`include "assert_macros.svh"

module macroman_utf8_transcoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,    // direction
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // out_byte
  output logic       out_tlast     // last_of_run
);

  logic        dir_r;
  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  rem_r, rem_nxt;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;

  logic [7:0]  ob_byte_r [3];
  logic [2:0]  ob_last_r;
  logic [1:0]  ob_cnt_r;

  logic        pop, buf_free, s1_adv, in_acc;
  logic [15:0] cp_fwd, cp_rev;
  mu8_pkg::res_t res;

  assign pop      = out_tvalid && out_tready;
  assign buf_free = (ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && pop);
  assign s1_adv   = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || buf_free;
  assign in_acc   = in_tvalid && in_tready;

  assign out_tvalid = (ob_cnt_r != 2'd0);
  assign out_tdata  = ob_byte_r[0];
  assign out_tlast  = ob_last_r[0];

  assign cp_fwd = mu8_pkg::roman_to_ucs(s1_byte_r);
  assign cp_rev = pend_r | {10'd0, s1_byte_r[5:0]};

  always_comb begin
    res      = '0;
    pend_nxt = pend_r;
    rem_nxt  = rem_r;
    if (s1_byte_r == 8'h00) begin
      pend_nxt = '0;
      rem_nxt  = '0;
    end else if (dir_r == mu8_pkg::DIR_ROMAN_TO_UTF8) begin
      priority if (cp_fwd < 16'h0080) begin
        res.cnt   = 2'd1;
        res.byte0 = cp_fwd[7:0];
        res.last  = 3'b001;
      end else if (cp_fwd < 16'h0800) begin
        res.cnt   = 2'd2;
        res.byte0 = mu8_pkg::UTF8_LEAD2 | {3'b000, cp_fwd[10:6]};
        res.byte1 = mu8_pkg::UTF8_CONT | {2'b00, cp_fwd[5:0]};
        res.last  = 3'b010;
      end else begin
        res.cnt   = 2'd3;
        res.byte0 = mu8_pkg::UTF8_LEAD3 | {4'h0, cp_fwd[15:12]};
        res.byte1 = mu8_pkg::UTF8_CONT | {2'b00, cp_fwd[11:6]};
        res.byte2 = mu8_pkg::UTF8_CONT | {2'b00, cp_fwd[5:0]};
        res.last  = 3'b100;
      end
    end else begin
      priority if (rem_r == 2'd0) begin
        priority if (s1_byte_r < 8'h80) begin
          res.cnt   = 2'd1;
          res.byte0 = s1_byte_r;
          res.last  = 3'b001;
        end else if (s1_byte_r < mu8_pkg::UTF8_LEAD3) begin
          pend_nxt = {5'd0, s1_byte_r[4:0], 6'd0};
          rem_nxt  = 2'd1;
        end else begin
          pend_nxt = {s1_byte_r[3:0], 12'd0};
          rem_nxt  = 2'd2;
        end
      end else if (rem_r == 2'd2) begin
        pend_nxt = pend_r | {4'd0, s1_byte_r[5:0], 6'd0};
        rem_nxt  = 2'd1;
      end else begin
        res.cnt   = 2'd1;
        res.byte0 = mu8_pkg::ucs_to_roman(cp_rev);
        res.last  = 3'b001;
        pend_nxt  = '0;
        rem_nxt   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= mu8_pkg::DIR_ROMAN_TO_UTF8;
      pend_r <= '0;
      rem_r  <= '0;
    end else if (cfg_we) begin
      dir_r  <= cfg_wdata;
      pend_r <= '0;
      rem_r  <= '0;
    end else if (s1_adv) begin
      pend_r <= pend_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= '0;
    end else if (s1_adv) begin
      ob_cnt_r <= res.cnt;
    end else if (pop) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ob_byte_r[0] <= res.byte0;
      ob_byte_r[1] <= res.byte1;
      ob_byte_r[2] <= res.byte2;
      ob_last_r    <= res.last;
    end else if (pop) begin
      ob_byte_r[0] <= ob_byte_r[1];
      ob_byte_r[1] <= ob_byte_r[2];
      ob_last_r    <= {1'b0, ob_last_r[2:1]};
    end
  end

  `ASSERT_CLK(a_final_flagged, (ob_cnt_r == 2'd1) |-> ob_last_r[0], "final buffered item not flagged last")
  `ASSERT_CLK(a_partial_dir1, (rem_r != 2'd0) |-> (dir_r == mu8_pkg::DIR_UTF8_TO_ROMAN), "partial sequence in direction 0")
  `ASSERT_CLK(a_s1_hold, (s1_valid_r && !buf_free) |=> (s1_valid_r && $stable(s1_byte_r)), "input register overwritten while blocked")
  `ASSERT_NEVER(a_no_load_busy, s1_adv && (ob_cnt_r > 2'd1), "result buffer loaded while holding items")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Mac Roman / UTF-8 byte-stream transcoder core
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] data;
  logic       last;
} out_byte_t;

class roman_utf8_board;
  logic [15:0] upper_ucs [128];
  logic        dir;
  logic [15:0] code;
  logic [1:0]  remaining;
  out_byte_t   expected_bytes [$];
  int          errors;
  int          checked;

  function new();
    upper_ucs = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };
    dir       = mu8_pkg::DIR_ROMAN_TO_UTF8;
    code      = '0;
    remaining = '0;
    errors    = 0;
    checked   = 0;
  endfunction

  function logic [15:0] ucs_of(logic [7:0] b);
    return b[7] ? upper_ucs[b[6:0]] : {8'h00, b};
  endfunction

  function logic [7:0] roman_of(logic [15:0] cp);
    logic [7:0] r;
    r = mu8_pkg::CHAR_QUESTION;
    if (cp <= 16'h007F) begin
      r = cp[7:0];
    end else begin
      for (int k = 0; k < 128; k++) begin
        if (upper_ucs[k] == cp) r = 8'h80 | 8'(k);
      end
    end
    return r;
  endfunction

  function int utf8_of(input logic [15:0] cp, output logic [7:0] seq [3]);
    seq = '{8'h00, 8'h00, 8'h00};
    if (cp < 16'h0080) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 16'h0800) begin
      seq[0] = mu8_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
      seq[1] = mu8_pkg::UTF8_CONT | {2'b00, cp[5:0]};
      return 2;
    end
    seq[0] = mu8_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]};
    seq[1] = mu8_pkg::UTF8_CONT | {2'b00, cp[11:6]};
    seq[2] = mu8_pkg::UTF8_CONT | {2'b00, cp[5:0]};
    return 3;
  endfunction

  function void set_direction(logic d);
    dir       = d;
    code      = '0;
    remaining = '0;
  endfunction

  function void expect_byte(logic [7:0] data, logic last);
    out_byte_t item;
    item.data      = data;
    item.last      = last;
    expected_bytes = {expected_bytes, item};
  endfunction

  function void note_in_byte(logic [7:0] b);
    logic [7:0] seq [3];
    int         n;
    if (b == 8'h00) begin
      code      = '0;
      remaining = '0;
    end else if (dir == mu8_pkg::DIR_ROMAN_TO_UTF8) begin
      n = utf8_of(ucs_of(b), seq);
      for (int i = 0; i < n; i++) expect_byte(seq[i], i == n - 1);
    end else if (remaining == 2'd0) begin
      if (b < 8'h80) begin
        expect_byte(b, 1'b1);
      end else if (b < mu8_pkg::UTF8_LEAD3) begin
        code      = {5'b0, b[4:0], 6'b0};
        remaining = 2'd1;
      end else begin
        code      = {b[3:0], 12'b0};
        remaining = 2'd2;
      end
    end else if (remaining == 2'd2) begin
      code      = code | {4'b0, b[5:0], 6'b0};
      remaining = 2'd1;
    end else begin
      code = code | {10'b0, b[5:0]};
      expect_byte(roman_of(code), 1'b1);
      code      = '0;
      remaining = '0;
    end
  endfunction

  function void check_out_byte(logic [7:0] data, logic last);
    out_byte_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected item: out_byte %02h last_of_run %b", data, last);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    checked++;
    if (data !== want.data) begin
      $error("out_byte: expected %02h, actual %02h", want.data, data);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_of_run: expected %b, actual %b", want.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RUN_ITEMS   = 9;

  localparam logic [7:0] ROMAN_PROBES [7] = '{
    8'h41, 8'h7F, 8'h80, 8'hA0, 8'hF0, 8'hFF, 8'h00
  };
  localparam logic [7:0] UTF8_PROBES [18] = '{
    8'h41, 8'hC3, 8'h84, 8'hE2, 8'h80, 8'hA0, 8'hCB, 8'h87, 8'hC0,
    8'h80, 8'h85, 8'h81, 8'hE2, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic       cfg_wdata  = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  roman_utf8_board board;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  macroman_utf8_transcoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // in_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // out_byte
    .out_tlast  (out_tlast)    // last_of_run
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_out_byte(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    board.note_in_byte(b);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    board.set_direction(d);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_roman_run(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_utf8_run(input int n);
    logic [7:0] seq [3];
    int         len;
    int         roll;
    int         sent;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < 85) begin
        // well-formed from the charset, or an arbitrary code point
        if (roll < 70) len = board.utf8_of(board.ucs_of(8'($urandom_range(1, 255))), seq);
        else len = board.utf8_of(16'($urandom_range(16'h0080, 16'hFFFF)), seq);
        for (int i = 0; i < len; i++) send_byte(seq[i]);
        sent += len;
      end else if (roll < 93) begin
        // truncate, then maybe end the string
        len = board.utf8_of(board.ucs_of(8'($urandom_range(8'h80, 255))), seq);
        len = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++) send_byte(seq[i]);
        sent += len;
        if ($urandom_range(1)) begin
          send_byte(8'h00);
          sent++;
        end
      end else begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_direction(mu8_pkg::DIR_ROMAN_TO_UTF8);
    foreach (ROMAN_PROBES[i]) send_byte(ROMAN_PROBES[i]);
    write_direction(mu8_pkg::DIR_UTF8_TO_ROMAN);
    foreach (UTF8_PROBES[i]) send_byte(UTF8_PROBES[i]);
    // drop a partial sequence by rewriting the direction
    send_byte(8'hE2);
    write_direction(mu8_pkg::DIR_UTF8_TO_ROMAN);
    send_byte(8'h41);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      write_direction(mu8_pkg::DIR_ROMAN_TO_UTF8);
      send_roman_run(RUN_ITEMS);
      write_direction(mu8_pkg::DIR_UTF8_TO_ROMAN);
      send_utf8_run(RUN_ITEMS);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d input items in both directions under four handshake mixes,",
             items_sent);
    $display("%0d output items compared against the predicted byte stream", board.checked);
    if (board.errors == 0 && board.expected_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mu8_pkg.sv
rtl/core/macroman_utf8_transcoder_core.sv
tb/tb.sv
